// ===== design/qte_pkg.sv =====
`default_nettype none

package qte_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int ITER_MAX = 24;

    localparam int IN_W = 16;
    localparam int SUM_W = IN_W + 1;
    localparam int PROD_W = 2 * IN_W;
    localparam int SQ_W = 2 * SUM_W;
    localparam int ARG_W = 36;
    localparam int AB_W = 34;
    localparam int WIDE_W = 64;
    localparam int HALF_W = 32;
    localparam int ANG_W = 26;
    localparam int PITCH_W = 15;
    localparam int ANGLE_W = 16;

    // Fixed scale applied to the sqrt operands and to the pitch sine.
    localparam int SQ_SHIFT = 30;
    // The CORDIC input is scaled so that the larger magnitude lands in [2^39, 2^40).
    localparam int NORM_BITS = 40;
    localparam int Q7_SHIFT = 9;
    localparam int ROUND_HALF = 256;

    localparam int N_LANES = 3;
    localparam int LANE_PITCH = 0;
    localparam int LANE_YAW = 1;
    localparam int LANE_ROLL = 2;

    typedef logic signed [IN_W-1:0] t_q;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SQ_W-1:0] t_sq;
    typedef logic signed [ARG_W-1:0] t_arg;
    typedef logic [AB_W-1:0] t_ab;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [WIDE_W-1:0] t_uwide;
    typedef logic [HALF_W-1:0] t_half;
    typedef logic signed [ANG_W-1:0] t_ang;
    typedef logic signed [PITCH_W-1:0] t_pitch;
    typedef logic signed [ANGLE_W-1:0] t_angle;

    localparam t_wide NORM_TOP = t_wide'(1) <<< NORM_BITS;
    localparam t_ang DEG90 = 26'sd5898240;
    localparam t_ang PITCH_LIM = 26'sd11520;
    localparam t_ang ANGLE_LIM = 26'sd23040;

    typedef struct packed {
        t_arg yaw_y;
        t_arg yaw_x;
        t_arg roll_y;
        t_arg roll_x;
        t_arg s;
        logic zero;
        logic hi;
        logic lo;
    } t_side;

    typedef struct packed {
        t_ab   a;
        t_ab   b;
        t_side side;
    } t_front;

    typedef struct packed {
        t_uwide c;
        t_side  side;
    } t_mid;

    typedef struct packed {
        t_wide x;
        t_wide y;
        t_ang  ang;
    } t_lane;

    typedef struct packed {
        logic               zero;
        logic               hi;
        logic               lo;
        logic [N_LANES-1:0] nul;
    } t_cflag;

    // atan(2^-i) in degrees scaled by 2^16.
    function automatic t_ang f_atan(input int i);
        t_ang r;
        case (i)
            0: r = 26'sd2949120;
            1: r = 26'sd1740967;
            2: r = 26'sd919879;
            3: r = 26'sd466945;
            4: r = 26'sd234379;
            5: r = 26'sd117304;
            6: r = 26'sd58666;
            7: r = 26'sd29335;
            8: r = 26'sd14668;
            9: r = 26'sd7334;
            10: r = 26'sd3667;
            11: r = 26'sd1833;
            12: r = 26'sd917;
            13: r = 26'sd458;
            14: r = 26'sd229;
            15: r = 26'sd115;
            16: r = 26'sd57;
            17: r = 26'sd29;
            18: r = 26'sd14;
            19: r = 26'sd7;
            20: r = 26'sd4;
            21: r = 26'sd2;
            22: r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

    function automatic logic f_big(input t_wide v);
        return (v >= NORM_TOP) || (v <= -NORM_TOP);
    endfunction

    // Round half up to Q9.7 and clamp symmetrically.
    function automatic t_ang f_q7(input t_ang a, input t_ang lim);
        t_ang r;
        r = (a + t_ang'(ROUND_HALF)) >>> Q7_SHIFT;
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/qte_if.sv =====
`default_nettype none

interface qte_quat_if;
    logic        valid;
    logic        ready;
    qte_pkg::t_q quat_w;
    qte_pkg::t_q quat_x;
    qte_pkg::t_q quat_y;
    qte_pkg::t_q quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                    input ready);
    modport sink (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                  output ready);
endinterface

interface qte_euler_if;
    logic            valid;
    logic            ready;
    qte_pkg::t_pitch pitch_deg;
    qte_pkg::t_angle yaw_deg;
    qte_pkg::t_angle roll_deg;
    logic            zero_length;

    modport source (output valid, output pitch_deg, output yaw_deg, output roll_deg,
                    output zero_length, input ready);
    modport sink (input valid, input pitch_deg, input yaw_deg, input roll_deg,
                  input zero_length, output ready);
endinterface

`default_nettype wire

// ===== design/qte_front.sv =====
`default_nettype none

module qte_front (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    qte_quat_if.sink      i_quat,
    output qte_pkg::t_front o_data,
    output logic          o_valid,
    input  wire logic     i_ready
);

    localparam int NS = 4;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    qte_pkg::t_q    r_w, r_x, r_y, r_z;
    qte_pkg::t_sum  r_dwx, r_swx, r_dyz, r_syz;
    qte_pkg::t_prod r_ww, r_xx, r_yy, r_zz, r_wy, r_zx, r_wz, r_xy, r_wx, r_yz;
    qte_pkg::t_sq   r_a1, r_a2, r_b1, r_b2;
    qte_pkg::t_arg  r_n, r_p1, r_p2, r_p3, r_p4, r_s;
    qte_pkg::t_ab   r_a, r_b;
    qte_pkg::t_front r_out;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_quat.ready = w_en[0];
    assign o_valid = r_v[NS-1];
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_quat.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_w <= i_quat.quat_w;
            r_x <= i_quat.quat_x;
            r_y <= i_quat.quat_y;
            r_z <= i_quat.quat_z;
            r_dwx <= qte_pkg::t_sum'(i_quat.quat_w) - qte_pkg::t_sum'(i_quat.quat_x);
            r_swx <= qte_pkg::t_sum'(i_quat.quat_w) + qte_pkg::t_sum'(i_quat.quat_x);
            r_dyz <= qte_pkg::t_sum'(i_quat.quat_y) - qte_pkg::t_sum'(i_quat.quat_z);
            r_syz <= qte_pkg::t_sum'(i_quat.quat_y) + qte_pkg::t_sum'(i_quat.quat_z);
        end
        if (w_en[1]) begin
            r_ww <= r_w * r_w;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_zz <= r_z * r_z;
            r_wy <= r_w * r_y;
            r_zx <= r_z * r_x;
            r_wz <= r_w * r_z;
            r_xy <= r_x * r_y;
            r_wx <= r_w * r_x;
            r_yz <= r_y * r_z;
            r_a1 <= r_dwx * r_dwx;
            r_a2 <= r_dyz * r_dyz;
            r_b1 <= r_swx * r_swx;
            r_b2 <= r_syz * r_syz;
        end
        if (w_en[2]) begin
            r_n <= qte_pkg::t_arg'(r_ww) + qte_pkg::t_arg'(r_xx)
                 + qte_pkg::t_arg'(r_yy) + qte_pkg::t_arg'(r_zz);
            r_p1 <= qte_pkg::t_arg'(r_wy) - qte_pkg::t_arg'(r_zx);
            r_p2 <= qte_pkg::t_arg'(r_yy) + qte_pkg::t_arg'(r_xx);
            r_p3 <= qte_pkg::t_arg'(r_wz) - qte_pkg::t_arg'(r_xy);
            r_p4 <= qte_pkg::t_arg'(r_xx) + qte_pkg::t_arg'(r_zz);
            r_s <= (qte_pkg::t_arg'(r_wx) + qte_pkg::t_arg'(r_yz)) <<< 1;
            r_a <= qte_pkg::t_ab'(r_a1 + r_a2);
            r_b <= qte_pkg::t_ab'(r_b1 + r_b2);
        end
        if (w_en[3]) begin
            r_out.a <= r_a;
            r_out.b <= r_b;
            r_out.side.yaw_y <= r_p1 <<< 1;
            r_out.side.yaw_x <= r_n - (r_p2 <<< 1);
            r_out.side.roll_y <= r_p3 <<< 1;
            r_out.side.roll_x <= r_n - (r_p4 <<< 1);
            r_out.side.s <= r_s;
            r_out.side.zero <= (r_n == '0);
            r_out.side.hi <= (r_s >= r_n);
            r_out.side.lo <= (r_s <= -r_n);
        end
    end

endmodule

`default_nettype wire

// ===== design/qte_sqrt.sv =====
`default_nettype none

module qte_sqrt (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire qte_pkg::t_front i_data,
    input  wire logic     i_valid,
    output logic          o_ready,
    output qte_pkg::t_mid o_data,
    output logic          o_valid,
    input  wire logic     i_ready
);

    // One result bit per stage, then one stage for the product of both roots.
    localparam int NIT = qte_pkg::HALF_W;
    localparam int NS = NIT + 1;

    typedef struct packed {
        qte_pkg::t_uwide v;
        qte_pkg::t_uwide res;
    } t_step;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    t_step          r_sa [NIT];
    t_step          r_sb [NIT];
    t_step          n_sa [NIT];
    t_step          n_sb [NIT];
    qte_pkg::t_side r_side [NIT];
    qte_pkg::t_mid  r_mid;
    qte_pkg::t_half w_ra;
    qte_pkg::t_half w_rb;

    function automatic t_step f_step(input t_step p, input qte_pkg::t_uwide bitv);
        t_step o;
        qte_pkg::t_uwide trial;
        trial = p.res + bitv;
        if (p.v >= trial) begin
            o.v = p.v - trial;
            o.res = (p.res >> 1) + bitv;
        end else begin
            o.v = p.v;
            o.res = p.res >> 1;
        end
        return o;
    endfunction

    always_comb begin
        t_step pa;
        t_step pb;
        qte_pkg::t_uwide bitv;
        for (int j = 0; j < NIT; j++) begin
            if (j == 0) begin
                pa.v = qte_pkg::t_uwide'(i_data.a) << qte_pkg::SQ_SHIFT;
                pa.res = '0;
                pb.v = qte_pkg::t_uwide'(i_data.b) << qte_pkg::SQ_SHIFT;
                pb.res = '0;
            end else begin
                pa = r_sa[j-1];
                pb = r_sb[j-1];
            end
            bitv = qte_pkg::t_uwide'(1) << (2 * (NIT - 1 - j));
            n_sa[j] = f_step(pa, bitv);
            n_sb[j] = f_step(pb, bitv);
        end
    end

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS-1];
    assign o_data = r_mid;
    assign w_ra = r_sa[NIT-1].res[qte_pkg::HALF_W-1:0];
    assign w_rb = r_sb[NIT-1].res[qte_pkg::HALF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NIT; j++) begin
            if (w_en[j]) begin
                r_sa[j] <= n_sa[j];
                r_sb[j] <= n_sb[j];
                r_side[j] <= (j == 0) ? i_data.side : r_side[j-1];
            end
        end
        if (w_en[NS-1]) begin
            r_mid.c <= w_ra * w_rb;
            r_mid.side <= r_side[NIT-1];
        end
    end

endmodule

`default_nettype wire

// ===== design/qte_cordic.sv =====
`default_nettype none

module qte_cordic #(
    parameter int ANGLE_ITERATIONS = qte_pkg::ANGLE_ITERATIONS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire qte_pkg::t_mid i_data,
    input  wire logic     i_valid,
    output logic          o_ready,
    qte_euler_if.source   o_euler
);

    localparam int NI = (ANGLE_ITERATIONS > qte_pkg::ITER_MAX) ?
                        qte_pkg::ITER_MAX : ANGLE_ITERATIONS;
    // Scaling stages: right shifts by 16..1, then left shifts by 32..1.
    localparam int N_RIGHT = 5;
    localparam int N_LEFT = 6;
    localparam int QUAD_IDX = N_RIGHT + N_LEFT;
    localparam int IT0 = QUAD_IDX + 1;
    localparam int NS_CORE = IT0 + NI;
    localparam int NS = NS_CORE + 1;
    localparam int L = qte_pkg::N_LANES;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    qte_pkg::t_lane  w_in [L];
    qte_pkg::t_cflag w_fin;
    qte_pkg::t_lane  r_ln [NS_CORE][L];
    qte_pkg::t_lane  n_ln [NS_CORE][L];
    qte_pkg::t_cflag r_fl [NS_CORE];

    qte_pkg::t_pitch r_pitch;
    qte_pkg::t_angle r_yaw;
    qte_pkg::t_angle r_roll;
    logic            r_zero;

    function automatic qte_pkg::t_lane f_right(input qte_pkg::t_lane p, input int s);
        qte_pkg::t_lane o;
        o = p;
        if (qte_pkg::f_big(p.x >>> (s - 1)) || qte_pkg::f_big(p.y >>> (s - 1))) begin
            o.x = p.x >>> s;
            o.y = p.y >>> s;
        end
        return o;
    endfunction

    function automatic qte_pkg::t_lane f_left(input qte_pkg::t_lane p, input int s);
        qte_pkg::t_lane o;
        qte_pkg::t_wide lim;
        o = p;
        lim = qte_pkg::NORM_TOP >>> s;
        if (p.x < lim && p.x > -lim && p.y < lim && p.y > -lim) begin
            o.x = p.x <<< s;
            o.y = p.y <<< s;
        end
        return o;
    endfunction

    // Fold the left half plane into the right one by a quarter turn.
    function automatic qte_pkg::t_lane f_quad(input qte_pkg::t_lane p);
        qte_pkg::t_lane o;
        o = p;
        if (p.x < 0) begin
            if (p.y >= 0) begin
                o.x = p.y;
                o.y = -p.x;
                o.ang = qte_pkg::DEG90;
            end else begin
                o.x = -p.y;
                o.y = p.x;
                o.ang = -qte_pkg::DEG90;
            end
        end
        return o;
    endfunction

    function automatic qte_pkg::t_lane f_iter(input qte_pkg::t_lane p, input int i);
        qte_pkg::t_lane o;
        qte_pkg::t_wide dx;
        qte_pkg::t_wide dy;
        dx = p.y >>> i;
        dy = p.x >>> i;
        if (p.y > 0) begin
            o.x = p.x + dx;
            o.y = p.y - dy;
            o.ang = p.ang + qte_pkg::f_atan(i);
        end else begin
            o.x = p.x - dx;
            o.y = p.y + dy;
            o.ang = p.ang - qte_pkg::f_atan(i);
        end
        return o;
    endfunction

    always_comb begin
        w_in[qte_pkg::LANE_PITCH].y = qte_pkg::t_wide'(i_data.side.s) <<< qte_pkg::SQ_SHIFT;
        w_in[qte_pkg::LANE_PITCH].x = qte_pkg::t_wide'(i_data.c);
        w_in[qte_pkg::LANE_YAW].y = qte_pkg::t_wide'(i_data.side.yaw_y);
        w_in[qte_pkg::LANE_YAW].x = qte_pkg::t_wide'(i_data.side.yaw_x);
        w_in[qte_pkg::LANE_ROLL].y = qte_pkg::t_wide'(i_data.side.roll_y);
        w_in[qte_pkg::LANE_ROLL].x = qte_pkg::t_wide'(i_data.side.roll_x);
        w_fin.zero = i_data.side.zero;
        w_fin.hi = i_data.side.hi;
        w_fin.lo = i_data.side.lo;
        for (int l = 0; l < L; l++) begin
            w_in[l].ang = '0;
            w_fin.nul[l] = (w_in[l].x == '0) && (w_in[l].y == '0);
        end
    end

    always_comb begin
        qte_pkg::t_lane p;
        for (int k = 0; k < NS_CORE; k++) begin
            for (int l = 0; l < L; l++) begin
                p = (k == 0) ? w_in[l] : r_ln[k-1][l];
                if (k < N_RIGHT) begin
                    n_ln[k][l] = f_right(p, 16 >> k);
                end else if (k < QUAD_IDX) begin
                    n_ln[k][l] = f_left(p, 32 >> (k - N_RIGHT));
                end else if (k == QUAD_IDX) begin
                    n_ln[k][l] = f_quad(p);
                end else begin
                    n_ln[k][l] = f_iter(p, k - IT0);
                end
            end
        end
    end

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || o_euler.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_euler.valid = r_v[NS-1];
    assign o_euler.pitch_deg = r_pitch;
    assign o_euler.yaw_deg = r_yaw;
    assign o_euler.roll_deg = r_roll;
    assign o_euler.zero_length = r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS_CORE; k++) begin
            if (w_en[k]) begin
                for (int l = 0; l < L; l++) begin
                    r_ln[k][l] <= n_ln[k][l];
                end
                r_fl[k] <= (k == 0) ? w_fin : r_fl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_zero <= r_fl[NS_CORE-1].zero;
            if (r_fl[NS_CORE-1].zero) begin
                r_pitch <= '0;
                r_yaw <= '0;
                r_roll <= '0;
            end else begin
                if (r_fl[NS_CORE-1].hi) begin
                    r_pitch <= qte_pkg::t_pitch'(qte_pkg::PITCH_LIM);
                end else if (r_fl[NS_CORE-1].lo) begin
                    r_pitch <= qte_pkg::t_pitch'(-qte_pkg::PITCH_LIM);
                end else if (r_fl[NS_CORE-1].nul[qte_pkg::LANE_PITCH]) begin
                    r_pitch <= '0;
                end else begin
                    r_pitch <= qte_pkg::t_pitch'(qte_pkg::f_q7(
                        r_ln[NS_CORE-1][qte_pkg::LANE_PITCH].ang, qte_pkg::PITCH_LIM));
                end
                if (r_fl[NS_CORE-1].nul[qte_pkg::LANE_YAW]) begin
                    r_yaw <= '0;
                end else begin
                    r_yaw <= qte_pkg::t_angle'(qte_pkg::f_q7(
                        r_ln[NS_CORE-1][qte_pkg::LANE_YAW].ang, qte_pkg::ANGLE_LIM));
                end
                if (r_fl[NS_CORE-1].nul[qte_pkg::LANE_ROLL]) begin
                    r_roll <= '0;
                end else begin
                    r_roll <= qte_pkg::t_angle'(qte_pkg::f_q7(
                        r_ln[NS_CORE-1][qte_pkg::LANE_ROLL].ang, qte_pkg::ANGLE_LIM));
                end
            end
        end
    end

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> (o_euler.pitch_deg <= 15'sd11520 && o_euler.pitch_deg >= -15'sd11520))
        else $error("pitch out of range");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> (o_euler.yaw_deg <= 16'sd23040 && o_euler.yaw_deg >= -16'sd23040
                        && o_euler.roll_deg <= 16'sd23040 && o_euler.roll_deg >= -16'sd23040))
        else $error("yaw or roll out of range");

    a_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_euler.valid && o_euler.zero_length) |->
            (o_euler.pitch_deg == '0 && o_euler.yaw_deg == '0 && o_euler.roll_deg == '0))
        else $error("zero-length word with nonzero angles");

endmodule

`default_nettype wire

// ===== design/quaternion_to_euler_top.sv =====
// Throughput: one word per cycle while the output is not stalled; 4 product/sum stages,
// 33 square-root and multiply stages, then 11 scaling stages, one quadrant stage, one
// CORDIC stage per iteration and one rounding stage, with ANGLE_ITERATIONS above 24
// acting as 24. Empty stages close up under back-pressure.
// Reset: synchronous, active low; it clears only the stage valid bits.
`default_nettype none

module quaternion_to_euler_top #(
    parameter int ANGLE_ITERATIONS = qte_pkg::ANGLE_ITERATIONS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler
);

    qte_pkg::t_front w_f_data;
    logic            w_f_valid;
    logic            w_f_ready;
    qte_pkg::t_mid   w_m_data;
    logic            w_m_valid;
    logic            w_m_ready;

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (i_quat),
        .o_data  (w_f_data),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready)
    );

    qte_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_f_data),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .o_data  (w_m_data),
        .o_valid (w_m_valid),
        .i_ready (w_m_ready)
    );

    qte_cordic #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_m_data),
        .i_valid (w_m_valid),
        .o_ready (w_m_ready),
        .o_euler (o_euler)
    );

endmodule

`default_nettype wire
